// ===== hw/rtl/ksrt_pkg.sv =====
// Shared constants and types of the keyed score record table.
`timescale 1ns / 1ps
package ksrt_pkg;

   localparam int DEPTH   = 1024;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int CNT_W   = ADDR_W + 1;
   localparam int CMD_W   = 2;
   localparam int KEY_W   = 30;
   localparam int SCORE_W = 20;
   localparam int TOTAL_W = 22;
   localparam int STAT_W  = 2;
   localparam int RANK_W  = 11;

   // Division by three: x * ceil(2^23 / 3) >> 23 is exact for any 22-bit x
   localparam int RECIP_SH = TOTAL_W + 1;
   localparam int PROD_W   = 2 * TOTAL_W;
   localparam logic [TOTAL_W-1:0] RECIP = TOTAL_W'(((64'd1 << RECIP_SH) + 64'd2) / 64'd3);

   // Command codes
   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;
   localparam logic [CMD_W-1:0] CMD_RANK   = 2'd3;

   // Status codes
   localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [SCORE_W-1:0] science;
      logic [SCORE_W-1:0] math;
      logic [SCORE_W-1:0] english;
      logic [TOTAL_W-1:0] total;
   } record_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      record_type        wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [SCORE_W-1:0] found_english;
      logic [SCORE_W-1:0] found_math;
      logic [SCORE_W-1:0] found_science;
      logic [TOTAL_W-1:0] found_total;
      logic [SCORE_W-1:0] found_average;
      logic [RANK_W-1:0]  rank_english;
      logic [RANK_W-1:0]  rank_math;
      logic [RANK_W-1:0]  rank_science;
      logic [RANK_W-1:0]  rank_total;
   } result_type;

endpackage

// ===== hw/rtl/ksrt_mem.sv =====
// Record memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps
module ksrt_mem (
   input  logic                 clock,
   input  ksrt_pkg::mem_req_type mem_req,
   output ksrt_pkg::record_type  rd_data
);
   import ksrt_pkg::*;

   record_type mem [DEPTH];
   record_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/ksrt_ctrl.sv =====
// Command sequencer: append, scan with rank counting, shift-down on delete and average on search hit.
`timescale 1ns / 1ps
module ksrt_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [ksrt_pkg::CMD_W-1:0]   req_cmd,
   input  logic [ksrt_pkg::KEY_W-1:0]   req_key,
   input  logic [ksrt_pkg::SCORE_W-1:0] req_english_score,
   input  logic [ksrt_pkg::SCORE_W-1:0] req_math_score,
   input  logic [ksrt_pkg::SCORE_W-1:0] req_science_score,
   output ksrt_pkg::mem_req_type        mem_req,
   input  ksrt_pkg::record_type         rd_data,
   output logic                         res_valid,
   output ksrt_pkg::result_type         res,
   input  logic                         res_take
);
   import ksrt_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SCAN  = 6'b000010,
      ST_SHIFT = 6'b000100,
      ST_DIV   = 6'b001000,
      ST_AVG   = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CMD_W-1:0]   cmd_ff, cmd_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [SCORE_W-1:0] eng_ff, eng_in;
   logic [SCORE_W-1:0] math_ff, math_in;
   logic [SCORE_W-1:0] sci_ff, sci_in;
   logic [TOTAL_W-1:0] tot_ff, tot_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic               pend_ff, pend_in;
   logic [ADDR_W-1:0]  pidx_ff, pidx_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   result_type         res_ff, res_in;
   logic               issue;
   logic               hit;

   assign issue = (idx_ff < count_ff);
   assign hit   = pend_ff && (rd_data.key == key_ff) && (cmd_ff != CMD_RANK);

   // next-state logic
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      cmd_in   = cmd_ff;
      key_in   = key_ff;
      eng_in   = eng_ff;
      math_in  = math_ff;
      sci_in   = sci_ff;
      tot_in   = tot_ff;
      idx_in   = idx_ff;
      pend_in  = pend_ff;
      pidx_in  = pidx_ff;
      prod_in  = prod_ff;
      res_in   = res_ff;
      mem_req  = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in  = req_cmd;
               key_in  = req_key;
               eng_in  = req_english_score;
               math_in = req_math_score;
               sci_in  = req_science_score;
               tot_in  = TOTAL_W'(req_english_score) + TOTAL_W'(req_math_score)
                         + TOTAL_W'(req_science_score);
               res_in  = '0;
               res_in.rank_english = RANK_W'(1);
               res_in.rank_math    = RANK_W'(1);
               res_in.rank_science = RANK_W'(1);
               res_in.rank_total   = RANK_W'(1);
               idx_in  = '0;
               pend_in = 1'b0;
               if (req_cmd == CMD_ADD) begin
                  if (count_ff >= CNT_W'(DEPTH)) begin
                     res_in.status = STAT_FULL;
                  end else begin
                     mem_req.wr_en           = 1'b1;
                     mem_req.wr_addr         = count_ff[ADDR_W-1:0];
                     mem_req.wr_data.key     = req_key;
                     mem_req.wr_data.english = req_english_score;
                     mem_req.wr_data.math    = req_math_score;
                     mem_req.wr_data.science = req_science_score;
                     mem_req.wr_data.total   = tot_in;
                     count_in                = count_ff + CNT_W'(1);
                  end
                  state_in = ST_DONE;
               end else if (count_ff == '0) begin
                  if (req_cmd != CMD_RANK) begin
                     res_in.status = STAT_NOT_FOUND;
                  end
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end

         // walk the records in order, one read issued per cycle
         ST_SCAN: begin
            if (pend_ff && cmd_ff == CMD_RANK) begin
               if (rd_data.english > eng_ff)
                  res_in.rank_english = res_ff.rank_english + RANK_W'(1);
               if (rd_data.math > math_ff)
                  res_in.rank_math = res_ff.rank_math + RANK_W'(1);
               if (rd_data.science > sci_ff)
                  res_in.rank_science = res_ff.rank_science + RANK_W'(1);
               if (rd_data.total > tot_ff)
                  res_in.rank_total = res_ff.rank_total + RANK_W'(1);
            end
            if (hit) begin
               pend_in = 1'b0;
               if (cmd_ff == CMD_SEARCH) begin
                  res_in.found_english = rd_data.english;
                  res_in.found_math    = rd_data.math;
                  res_in.found_science = rd_data.science;
                  res_in.found_total   = rd_data.total;
                  state_in             = ST_DIV;
               end else begin
                  idx_in   = CNT_W'(pidx_ff) + CNT_W'(1);
                  state_in = ST_SHIFT;
               end
            end else begin
               if (issue) begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = idx_ff[ADDR_W-1:0];
                  pidx_in         = idx_ff[ADDR_W-1:0];
                  idx_in          = idx_ff + CNT_W'(1);
                  pend_in         = 1'b1;
               end else begin
                  pend_in = 1'b0;
               end
               if (!issue && !pend_ff) begin
                  if (cmd_ff != CMD_RANK) begin
                     res_in.status = STAT_NOT_FOUND;
                  end
                  state_in = ST_DONE;
               end
            end
         end

         // move each later record down by one place
         ST_SHIFT: begin
            if (pend_ff) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = pidx_ff - ADDR_W'(1);
               mem_req.wr_data = rd_data;
            end
            if (issue) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = idx_ff[ADDR_W-1:0];
               pidx_in         = idx_ff[ADDR_W-1:0];
               idx_in          = idx_ff + CNT_W'(1);
               pend_in         = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (!issue && !pend_ff) begin
               count_in = count_ff - CNT_W'(1);
               state_in = ST_DONE;
            end
         end

         // average = total / 3 by reciprocal multiply
         ST_DIV: begin
            prod_in  = PROD_W'(res_ff.found_total) * PROD_W'(RECIP);
            state_in = ST_AVG;
         end

         ST_AVG: begin
            res_in.found_average = prod_ff[RECIP_SH +: SCORE_W];
            state_in             = ST_DONE;
         end

         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      key_ff  <= key_in;
      eng_ff  <= eng_in;
      math_ff <= math_in;
      sci_ff  <= sci_in;
      tot_ff  <= tot_in;
      idx_ff  <= idx_in;
      pidx_ff <= pidx_in;
      prod_ff <= prod_in;
      res_ff  <= res_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);
   assign res       = res_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("record count beyond table depth");

   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (mem_req.wr_en && mem_req.rd_en) |-> (mem_req.wr_addr != mem_req.rd_addr))
      else $error("read and write to the same entry in one cycle");

   a_pend_in_range: assert property (@(posedge clock) disable iff (reset)
      (pend_ff && (state_ff == ST_SCAN || state_ff == ST_SHIFT))
      |-> (CNT_W'(pidx_ff) < count_ff))
      else $error("pending read beyond stored records");

   a_shift_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT && state_in == ST_DONE) |=> (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("delete did not shrink the table");
`endif

endmodule

// ===== hw/rtl/ksrt_rsp.sv =====
// Result output register between the sequencer and the rsp channel.
`timescale 1ns / 1ps
module ksrt_rsp (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 res_valid,
   input  ksrt_pkg::result_type res,
   output logic                 res_take,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ksrt_pkg::result_type rsp_data
);
   import ksrt_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   // load when the slot is empty or is being emptied
   assign res_take = res_valid && (!valid_ff || rsp_ready);

   always_comb begin
      valid_in = valid_ff;
      if (res_take) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         data_ff <= res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ===== hw/rtl/keyed_score_record_table_top.sv =====
// Top level of the keyed score record table.
// Add, or any command on an empty table, goes straight to a result; rank and a missing
// search or delete read every stored record, one record read per cycle from the memory port.
// A search hit stops at the match, then forms the average. A delete hit scans to the
// match, then shifts the later records down at one per cycle.
// One item at a time; next taken once its result is in the output register; reset clears count.
`timescale 1ns / 1ps
module keyed_score_record_table_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ksrt_pkg::CMD_W-1:0]    req_cmd,
   input  logic [ksrt_pkg::KEY_W-1:0]    req_key,
   input  logic [ksrt_pkg::SCORE_W-1:0]  req_english_score,
   input  logic [ksrt_pkg::SCORE_W-1:0]  req_math_score,
   input  logic [ksrt_pkg::SCORE_W-1:0]  req_science_score,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ksrt_pkg::STAT_W-1:0]   rsp_status,
   output logic [ksrt_pkg::SCORE_W-1:0]  rsp_found_english,
   output logic [ksrt_pkg::SCORE_W-1:0]  rsp_found_math,
   output logic [ksrt_pkg::SCORE_W-1:0]  rsp_found_science,
   output logic [ksrt_pkg::TOTAL_W-1:0]  rsp_found_total,
   output logic [ksrt_pkg::SCORE_W-1:0]  rsp_found_average,
   output logic [ksrt_pkg::RANK_W-1:0]   rsp_rank_english,
   output logic [ksrt_pkg::RANK_W-1:0]   rsp_rank_math,
   output logic [ksrt_pkg::RANK_W-1:0]   rsp_rank_science,
   output logic [ksrt_pkg::RANK_W-1:0]   rsp_rank_total
);
   import ksrt_pkg::*;

   mem_req_type mem_req;
   record_type  rd_data;
   result_type  res;
   result_type  rsp_data;
   logic        res_valid;
   logic        res_take;

   ksrt_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   ksrt_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_key           (req_key),
      .req_english_score (req_english_score),
      .req_math_score    (req_math_score),
      .req_science_score (req_science_score),
      .mem_req           (mem_req),
      .rd_data           (rd_data),
      .res_valid         (res_valid),
      .res               (res),
      .res_take          (res_take)
   );

   ksrt_rsp u_rsp (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .res_take  (res_take),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // unpack the result item onto its ports
   assign rsp_status        = rsp_data.status;
   assign rsp_found_english = rsp_data.found_english;
   assign rsp_found_math    = rsp_data.found_math;
   assign rsp_found_science = rsp_data.found_science;
   assign rsp_found_total   = rsp_data.found_total;
   assign rsp_found_average = rsp_data.found_average;
   assign rsp_rank_english  = rsp_data.rank_english;
   assign rsp_rank_math     = rsp_data.rank_math;
   assign rsp_rank_science  = rsp_data.rank_science;
   assign rsp_rank_total    = rsp_data.rank_total;

endmodule
